>>> hw/rtl/gdda_pkg.sv
// gdda_pkg: shared types, constants and codes of the grid DDA column ray caster.
// No dependencies.
package gdda_pkg;

    localparam int MAP_SIZE_DEF = 16;
    localparam int SCREEN_W_DEF = 120;
    localparam int SCREEN_H_DEF = 40;

    localparam int MAP_DEPTH = 16;
    localparam int MAP_AW    = 4;
    localparam int MAP_DW    = 16;

    localparam int DIV_NW    = 35;
    localparam int DIV_DW    = 32;
    localparam int DIV_CW    = 6;

    localparam int DIST_W    = 32;
    localparam logic [DIST_W-1:0] DIST_INF = '1;
    localparam logic [DIST_W-1:0] ONE_Q16  = 32'h0001_0000;

    localparam logic [6:0] CH_BLANK = 7'h20;
    localparam logic [6:0] CH_HASH  = 7'h23;
    localparam logic [6:0] CH_UX    = 7'h58;
    localparam logic [6:0] CH_M     = 7'h4D;
    localparam logic [6:0] CH_LX    = 7'h78;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_COMMA = 7'h2C;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CAST = 1'b1;

    typedef struct packed {
        logic               command;
        logic [6:0]         column;
        logic [3:0]         map_row;
        logic [15:0]        map_row_bits;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
    } t_in_beat;

    typedef struct packed {
        logic [5:0] row;
        logic [6:0] out_column;
        logic [6:0] pixel_char;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic              go;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CAM,
        S_MUL,
        S_RAY,
        S_DX,
        S_DY,
        S_SIDE,
        S_STEP,
        S_PROBE,
        S_PERP,
        S_LH,
        S_SPAN,
        S_EMIT
    } t_state;

endpackage

>>> hw/rtl/gdda_mem.sv
// gdda_mem: wall map store, one word per map row, registered read.
// Depends on gdda_pkg.
module gdda_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [gdda_pkg::MAP_AW-1:0] i_waddr,
    input  logic [gdda_pkg::MAP_DW-1:0] i_wdata,
    input  logic [gdda_pkg::MAP_AW-1:0] i_raddr,
    output logic [gdda_pkg::MAP_DW-1:0] o_rdata
);

    logic [gdda_pkg::MAP_DW-1:0] r_mem [gdda_pkg::MAP_DEPTH];
    logic [gdda_pkg::MAP_DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/gdda_div.sv
// gdda_div: shared restoring divider, one quotient bit per cycle.
// Depends on gdda_pkg.
module gdda_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gdda_pkg::t_div_req  i_req,
    output gdda_pkg::t_div_rsp  o_rsp
);

    localparam int NW = gdda_pkg::DIV_NW;
    localparam int DW = gdda_pkg::DIV_DW;
    localparam int CW = gdda_pkg::DIV_CW;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    assign rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? diff : rem_sh;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> hw/rtl/grid_dda_column_raycaster.sv
// grid_dda_column_raycaster: top level, cast sequencer around the wall map and divider.
// Depends on gdda_pkg, gdda_mem, gdda_div.
//
//  channel | valid      | stall       | beat
//  in      | i_in_valid | o_in_stall  | i_in_beat  (t_in_beat)
//  out     | o_out_valid| i_out_stall | o_out_beat (t_out_beat)
//
// A cast runs three divider passes (two deltas, height), a fourth for the wall distance
// on a hit, a step and a map read per grid step, and then SCREEN_H beats.
// Reset is synchronous, active low; the map holds no reset value.
// One item at a time; i_out_stall holds back the beats.
module grid_dda_column_raycaster #(
    parameter int MAP_SIZE = gdda_pkg::MAP_SIZE_DEF,
    parameter int SCREEN_W = gdda_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = gdda_pkg::SCREEN_H_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gdda_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gdda_pkg::t_out_beat o_out_beat
);

    localparam int NW  = gdda_pkg::DIV_NW;
    localparam int DW  = gdda_pkg::DIV_DW;
    localparam int H2  = SCREEN_H / 2;
    localparam int LIM = 2 * MAP_SIZE + 2;
    localparam logic [gdda_pkg::DIST_W-1:0] INF = gdda_pkg::DIST_INF;
    // reciprocal of SCREEN_W, exact floor for 22-bit numerators
    localparam logic [28:0] CAM_M =
        29'(((64'd1 << 29) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

    gdda_pkg::t_state    r_state, n_state;
    logic [6:0]          r_col, n_col;
    logic [15:0]         r_px, n_px, r_py, n_py;
    logic signed [15:0]  r_dirx, n_dirx, r_diry, n_diry;
    logic signed [15:0]  r_plx, n_plx, r_ply, n_ply;
    logic signed [15:0]  r_cam, n_cam;
    logic signed [31:0]  r_prodx, n_prodx, r_prody, n_prody;
    logic signed [17:0]  r_rx, n_rx, r_ry, n_ry;
    logic [31:0]         r_dx, n_dx, r_dy, n_dy;
    logic [31:0]         r_sdx, n_sdx, r_sdy, n_sdy;
    logic signed [5:0]   r_mx, n_mx, r_my, n_my;
    logic                r_side, n_side;
    logic [5:0]          r_cnt, n_cnt;
    logic                r_pinf, n_pinf, r_pzero, n_pzero;
    logic [31:0]         r_dist, n_dist;
    logic [15:0]         r_lh, n_lh;
    logic [5:0]          r_start, n_start, r_end, n_end;
    logic [6:0]          r_shade, n_shade;
    logic [5:0]          r_y, n_y;
    logic                r_div_go, n_div_go;
    logic [NW-1:0]       r_div_num, n_div_num;
    logic [DW-1:0]       r_div_den, n_div_den;
    logic                r_out_valid, n_out_valid;
    gdda_pkg::t_out_beat r_out_beat, n_out_beat;

    gdda_pkg::t_div_req  div_req;
    gdda_pkg::t_div_rsp  div_rsp;
    logic                mem_we;
    logic [15:0]         mem_rdata;
    logic [3:0]          mem_raddr;
    logic                emit;

    logic [44:0]         cam_prod;
    logic [17:0]         ax, ay;
    logic [12:0]         fx, fy;
    logic [44:0]         px_prod, py_prod;
    logic [32:0]         sum_x, sum_y;
    logic signed [5:0]   hit_cell, bound_cell;
    logic signed [18:0]  pnum;
    logic [17:0]         pabs;
    logic signed [17:0]  pr;
    logic [17:0]         prabs;
    logic [14:0]         half;
    logic [16:0]         hsum;
    logic [8:0]          y4;
    logic [6:0]          ch;

    assign div_req.go  = r_div_go;
    assign div_req.num = r_div_num;
    assign div_req.den = r_div_den;

    assign mem_we = (r_state == gdda_pkg::S_IDLE) && i_in_valid
                    && (i_in_beat.command == gdda_pkg::CMD_LOAD);

    gdda_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (i_in_beat.map_row),
        .i_wdata (i_in_beat.map_row_bits),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gdda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign emit = (r_state == gdda_pkg::S_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state; n_col = r_col; n_px = r_px; n_py = r_py;
        n_dirx = r_dirx; n_diry = r_diry; n_plx = r_plx; n_ply = r_ply;
        n_cam = r_cam; n_prodx = r_prodx; n_prody = r_prody;
        n_rx = r_rx; n_ry = r_ry; n_dx = r_dx; n_dy = r_dy;
        n_sdx = r_sdx; n_sdy = r_sdy; n_mx = r_mx; n_my = r_my;
        n_side = r_side; n_cnt = r_cnt; n_pinf = r_pinf; n_pzero = r_pzero;
        n_dist = r_dist; n_lh = r_lh; n_start = r_start; n_end = r_end;
        n_shade = r_shade; n_y = r_y;
        n_div_go = 1'b0; n_div_num = r_div_num; n_div_den = r_div_den;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_beat = r_out_beat;
        mem_raddr = r_my[3:0];

        cam_prod = 45'({r_col, 15'b0}) * 45'(CAM_M);

        ax = r_rx[17] ? 18'(-r_rx) : 18'(r_rx);
        ay = r_ry[17] ? 18'(-r_ry) : 18'(r_ry);
        fx = r_rx[17] ? {1'b0, r_px[11:0]} : 13'(13'd4096 - {1'b0, r_px[11:0]});
        fy = r_ry[17] ? {1'b0, r_py[11:0]} : 13'(13'd4096 - {1'b0, r_py[11:0]});
        px_prod = 45'(fx) * 45'(r_dx);
        py_prod = 45'(fy) * 45'(r_dy);
        sum_x = {1'b0, r_sdx} + {1'b0, r_dx};
        sum_y = {1'b0, r_sdy} + {1'b0, r_dy};

        hit_cell   = r_side ? r_my : r_mx;
        bound_cell = (r_side ? r_ry[17] : r_rx[17]) ? 6'(hit_cell + 6'sd1) : hit_cell;
        pnum  = 19'(signed'({bound_cell, 12'b0})) - signed'({3'b0, r_side ? r_py : r_px});
        pabs  = pnum[18] ? 18'(-pnum) : 18'(pnum);
        pr    = r_side ? r_ry : r_rx;
        prabs = r_side ? ay : ax;

        half = r_lh[15:1];
        hsum = 17'(half) + 17'(H2);
        y4   = {1'b0, r_y, 2'b00};

        if (r_y < r_start) begin
            ch = gdda_pkg::CH_BLANK;
        end else if (r_y <= r_end) begin
            ch = r_shade;
        end else if (y4 > 9'(3 * SCREEN_H)) begin
            ch = gdda_pkg::CH_COMMA;
        end else begin
            ch = gdda_pkg::CH_BLANK;
        end

        unique case (r_state)
            gdda_pkg::S_IDLE: begin
                if (i_in_valid && i_in_beat.command == gdda_pkg::CMD_CAST
                    && {1'b0, i_in_beat.column} < 8'(SCREEN_W)) begin
                    n_col = i_in_beat.column;
                    n_px = i_in_beat.pos_x; n_py = i_in_beat.pos_y;
                    n_dirx = i_in_beat.dir_x; n_diry = i_in_beat.dir_y;
                    n_plx = i_in_beat.plane_x; n_ply = i_in_beat.plane_y;
                    n_state = gdda_pkg::S_CAM;
                end
            end
            gdda_pkg::S_CAM: begin
                n_cam = signed'(cam_prod[44:29] - 16'd16384);
                n_state = gdda_pkg::S_MUL;
            end
            gdda_pkg::S_MUL: begin
                n_prodx = r_plx * r_cam;
                n_prody = r_ply * r_cam;
                n_state = gdda_pkg::S_RAY;
            end
            gdda_pkg::S_RAY: begin
                n_rx = 18'(r_dirx) + 18'(r_prodx >>> 14);
                n_ry = 18'(r_diry) + 18'(r_prody >>> 14);
                n_div_go = 1'b1;
                n_div_num = NW'(32'h4000_0000);
                n_div_den = DW'(n_rx[17] ? 18'(-n_rx) : 18'(n_rx));
                n_state = gdda_pkg::S_DX;
            end
            gdda_pkg::S_DX: begin
                if (div_rsp.done) begin
                    n_dx = (r_rx == '0) ? INF : div_rsp.quo[31:0];
                    n_div_go = 1'b1;
                    n_div_den = DW'(ay);
                    n_state = gdda_pkg::S_DY;
                end
            end
            gdda_pkg::S_DY: begin
                if (div_rsp.done) begin
                    n_dy = (r_ry == '0) ? INF : div_rsp.quo[31:0];
                    n_state = gdda_pkg::S_SIDE;
                end
            end
            gdda_pkg::S_SIDE: begin
                n_sdx = (r_dx == INF) ? ((fx == '0) ? '0 : INF) : 32'(px_prod >> 12);
                n_sdy = (r_dy == INF) ? ((fy == '0) ? '0 : INF) : 32'(py_prod >> 12);
                n_mx = signed'({2'b0, r_px[15:12]});
                n_my = signed'({2'b0, r_py[15:12]});
                n_cnt = '0;
                n_state = gdda_pkg::S_STEP;
            end
            gdda_pkg::S_STEP: begin
                if (r_cnt == 6'(LIM)) begin
                    n_dist = INF;
                    n_div_go = 1'b1;
                    n_div_num = NW'(SCREEN_H) << 16;
                    n_div_den = INF;
                    n_state = gdda_pkg::S_LH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_sdx < r_sdy) begin
                        n_sdx = sum_x[32] ? INF : sum_x[31:0];
                        n_mx = r_rx[17] ? 6'(r_mx - 6'sd1) : 6'(r_mx + 6'sd1);
                        n_side = 1'b0;
                    end else begin
                        n_sdy = sum_y[32] ? INF : sum_y[31:0];
                        n_my = r_ry[17] ? 6'(r_my - 6'sd1) : 6'(r_my + 6'sd1);
                        n_side = 1'b1;
                    end
                    mem_raddr = n_my[3:0];
                    if (n_mx[5] || n_my[5] || $unsigned(n_mx) >= 6'(MAP_SIZE)
                        || $unsigned(n_my) >= 6'(MAP_SIZE)) begin
                        n_dist = INF;
                        n_div_go = 1'b1;
                        n_div_num = NW'(SCREEN_H) << 16;
                        n_div_den = INF;
                        n_state = gdda_pkg::S_LH;
                    end else begin
                        n_state = gdda_pkg::S_PROBE;
                    end
                end
            end
            gdda_pkg::S_PROBE: begin
                if (mem_rdata[r_mx[3:0]]) begin
                    n_pinf = (pr == '0);
                    n_pzero = (pnum[18] != pr[17]) && (pnum != '0);
                    n_div_go = 1'b1;
                    n_div_num = NW'({pabs, 18'b0});
                    n_div_den = DW'(prabs);
                    n_state = gdda_pkg::S_PERP;
                end else begin
                    n_state = gdda_pkg::S_STEP;
                end
            end
            gdda_pkg::S_PERP: begin
                if (div_rsp.done) begin
                    if (r_pinf) begin
                        n_dist = INF;
                    end else if (r_pzero) begin
                        n_dist = '0;
                    end else if (div_rsp.quo[NW-1:32] != '0) begin
                        n_dist = INF;
                    end else begin
                        n_dist = div_rsp.quo[31:0];
                    end
                    n_div_go = 1'b1;
                    n_div_num = NW'(SCREEN_H) << 16;
                    n_div_den = n_dist;
                    n_state = gdda_pkg::S_LH;
                end
            end
            gdda_pkg::S_LH: begin
                if (div_rsp.done) begin
                    if (r_dist == '0) begin
                        n_lh = 16'(SCREEN_H);
                    end else if (div_rsp.quo[NW-1:16] != '0) begin
                        n_lh = '1;
                    end else begin
                        n_lh = div_rsp.quo[15:0];
                    end
                    n_state = gdda_pkg::S_SPAN;
                end
            end
            gdda_pkg::S_SPAN: begin
                n_start = (half >= 15'(H2)) ? '0 : 6'(15'(H2) - half);
                n_end = (hsum >= 17'(SCREEN_H - 1)) ? 6'(SCREEN_H - 1) : hsum[5:0];
                if (r_dist <= gdda_pkg::ONE_Q16) begin
                    n_shade = r_side ? gdda_pkg::CH_M : gdda_pkg::CH_HASH;
                end else if (r_dist < 32'h0002_0000) begin
                    n_shade = r_side ? gdda_pkg::CH_LX : gdda_pkg::CH_UX;
                end else if (r_dist < 32'h0003_0000) begin
                    n_shade = r_side ? gdda_pkg::CH_DASH : gdda_pkg::CH_LX;
                end else if (r_dist < 32'h0005_0000) begin
                    n_shade = gdda_pkg::CH_DOT;
                end else begin
                    n_shade = gdda_pkg::CH_BLANK;
                end
                n_y = '0;
                n_state = gdda_pkg::S_EMIT;
            end
            gdda_pkg::S_EMIT: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_beat.row = r_y;
                    n_out_beat.out_column = r_col;
                    n_out_beat.pixel_char = ch;
                    n_out_beat.last = (r_y == 6'(SCREEN_H - 1));
                    n_y = r_y + 1'b1;
                    if (r_y == 6'(SCREEN_H - 1)) begin
                        n_state = gdda_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = gdda_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdda_pkg::S_IDLE;
            r_div_go <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div_go <= n_div_go;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col; r_px <= n_px; r_py <= n_py;
        r_dirx <= n_dirx; r_diry <= n_diry; r_plx <= n_plx; r_ply <= n_ply;
        r_cam <= n_cam; r_prodx <= n_prodx; r_prody <= n_prody;
        r_rx <= n_rx; r_ry <= n_ry; r_dx <= n_dx; r_dy <= n_dy;
        r_sdx <= n_sdx; r_sdy <= n_sdy; r_mx <= n_mx; r_my <= n_my;
        r_side <= n_side; r_cnt <= n_cnt; r_pinf <= n_pinf; r_pzero <= n_pzero;
        r_dist <= n_dist; r_lh <= n_lh; r_start <= n_start; r_end <= n_end;
        r_shade <= n_shade; r_y <= n_y;
        r_div_num <= n_div_num; r_div_den <= n_div_den;
        r_out_beat <= n_out_beat;
    end

    assign o_in_stall  = (r_state != gdda_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_go |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_probe_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdda_pkg::S_PROBE) |-> ($past(r_state) == gdda_pkg::S_STEP))
        else $error("map probe without a grid step");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_y == 6'(SCREEN_H - 1)) |=> (r_state == gdda_pkg::S_IDLE && o_out_beat.last))
        else $error("column not closed on its last row");

endmodule
